@@ src/zeg_pkg.sv @@
// Package for the zigzag Elias gamma encoder: word types, microcode format
// and the control program. No dependencies.
`default_nettype none
package zeg_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int PC_BITS = 2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               end_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } code_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_NORM,
    OP_MERGE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_WAIT_IN,
    COND_NORM_MORE,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [PC_BITS-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic norm_more;
    logic emit_more;
  } status_t;

  localparam logic [PC_BITS-1:0] PC_LOAD  = PC_BITS'(0);
  localparam logic [PC_BITS-1:0] PC_NORM  = PC_BITS'(1);
  localparam logic [PC_BITS-1:0] PC_MERGE = PC_BITS'(2);
  localparam logic [PC_BITS-1:0] PC_EMIT  = PC_BITS'(3);

  // Branch to target when the condition holds, else fall through (wraps).
  function automatic uword_t ucode(input logic [PC_BITS-1:0] pc);
    uword_t w;
    case (pc)
      PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_WAIT_IN,   target: PC_LOAD};
      PC_NORM:  w = '{op: OP_NORM,  cond: COND_NORM_MORE, target: PC_NORM};
      PC_MERGE: w = '{op: OP_MERGE, cond: COND_NONE,      target: PC_LOAD};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_EMIT_MORE, target: PC_EMIT};
      default:  w = '{op: OP_LOAD,  cond: COND_WAIT_IN,   target: PC_LOAD};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ src/zigzag_elias_gamma_encoder.sv @@
// Top level of the zigzag Elias gamma encoder.
// Instantiates zeg_sequencer and zeg_datapath; uses zeg_pkg.
//
// Each signed value is zigzag mapped and written as an Elias gamma code,
// packed MSB-first into bytes; a value with end_of_stream set zero-pads and
// flags the final byte. One value at a time: it is taken in a load step,
// then the leading-zero search runs clog2(VALUE_BITS+1) steps (6 for 32
// bits), one merge step follows, then one emit step per byte produced (0 to
// 9 at 32 bits) unless the output stalls, plus one closing step. Bytes leave
// through a one-word output register.
`default_nettype none
module zigzag_elias_gamma_encoder #(
  parameter int VALUE_BITS = zeg_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire zeg_pkg::item_t item,
  output logic                code_valid,
  input  wire logic           code_stall,
  output zeg_pkg::code_t      code
);
  import zeg_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  assign item_stall = (ctrl.op != OP_LOAD);

  zeg_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .status     (status),
    .ctrl       (ctrl)
  );

  zeg_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .item       (item),
    .status     (status),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
  );

endmodule
`default_nettype wire

@@ src/zeg_sequencer.sv @@
// Microcode sequencer: step counter, program ROM and branch conditions.
// Depends on zeg_pkg.
`default_nettype none
module zeg_sequencer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire zeg_pkg::status_t status,
  output zeg_pkg::ctrl_t        ctrl
);
  import zeg_pkg::*;

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  uword_t             uw;
  logic               branch;

  assign uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      COND_NONE:      branch = 1'b0;
      COND_WAIT_IN:   branch = !item_valid;
      COND_NORM_MORE: branch = status.norm_more;
      COND_EMIT_MORE: branch = status.emit_more;
      default:        branch = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = branch ? uw.target : pc + PC_BITS'(1);
  end

  always_comb begin
    ctrl.op   = uw.op;
    ctrl.take = (uw.op == OP_LOAD) && item_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

@@ src/zeg_datapath.sv @@
// Datapath: zigzag map, leading-zero normalization, bit merge and byte
// output register. Driven by the control word of zeg_sequencer; uses zeg_pkg.
`default_nettype none
module zeg_datapath #(
  parameter int VALUE_BITS = zeg_pkg::VALUE_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire zeg_pkg::ctrl_t   ctrl,
  input  wire zeg_pkg::item_t   item,
  output zeg_pkg::status_t      status,
  output logic                  code_valid,
  input  wire logic             code_stall,
  output zeg_pkg::code_t        code
);
  import zeg_pkg::*;

  localparam int MW = VALUE_BITS + 1;
  localparam int NS = $clog2(MW);
  localparam int KW = $clog2(NS);
  localparam int WW = 2 * MW - 1;
  localparam int RW = WW + 8;
  localparam int TW = $clog2(RW + 1);

  logic [MW-1:0]         m_reg;
  logic [WW-1:0]         w_reg;
  logic [TW-1:0]         len_reg;
  logic [KW-1:0]         k;
  logic                  eos;
  logic [RW-1:0]         r_reg;
  logic [TW-1:0]         t_reg;
  logic [7:0]            bit_buffer;
  logic [2:0]            bit_count;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [MW-1:0]         m_load;
  logic [NS:0]           sh;
  logic [MW-1:0]         top_mask;
  logic                  top_zero;
  logic [3:0]            lsh;
  logic [RW-1:0]         r_merge;
  logic                  emit_need;
  logic                  out_load;
  logic                  last;

  assign raw    = item.value[VALUE_BITS-1:0];
  assign mag    = ~raw + VALUE_BITS'(1);
  assign m_load = raw[VALUE_BITS-1] ? {mag, 1'b0} : {raw, 1'b1};

  assign sh       = {{NS{1'b0}}, 1'b1} << k;
  assign top_mask = ~({MW{1'b1}} >> sh);
  assign top_zero = (m_reg & top_mask) == '0;

  assign lsh     = 4'd8 - {1'b0, bit_count};
  assign r_merge = {bit_buffer, {WW{1'b0}}} | ({8'b0, w_reg} << lsh);

  assign emit_need = (t_reg >= TW'(8)) || (eos && (t_reg != '0));
  assign out_load  = (ctrl.op == OP_EMIT) && emit_need && (!code_valid || !code_stall);
  assign last      = eos && (t_reg <= TW'(8));

  assign status.norm_more = (k != '0);
  assign status.emit_more = emit_need;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.take) begin
          m_reg   <= m_load;
          w_reg   <= {{(MW-1){1'b0}}, m_load};
          len_reg <= TW'(WW);
          k       <= KW'(NS - 1);
          eos     <= item.end_of_stream;
        end
      end
      OP_NORM: begin
        if (top_zero) begin
          m_reg   <= m_reg << sh;
          w_reg   <= w_reg << {sh, 1'b0};
          len_reg <= len_reg - TW'({sh, 1'b0});
        end
        k <= k - KW'(1);
      end
      OP_MERGE: begin
        r_reg <= r_merge;
        t_reg <= TW'(bit_count) + len_reg;
      end
      OP_EMIT: begin
        if (out_load) begin
          r_reg <= r_reg << 8;
          t_reg <= (t_reg >= TW'(8)) ? t_reg - TW'(8) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer <= '0;
      bit_count  <= '0;
    end else if ((ctrl.op == OP_EMIT) && !emit_need) begin
      bit_buffer <= r_reg[RW-1 -: 8];
      bit_count  <= t_reg[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (out_load) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      code.out_byte  <= r_reg[RW-1 -: 8];
      code.last_byte <= last;
    end
  end

  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(code_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("byte loaded outside emit step");

  a_stream_end_empty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT) && !emit_need && eos |=> bit_count == 3'd0)
    else $error("bits pending after stream end");

  a_merge_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_MERGE |=> t_reg <= TW'(RW - 1))
    else $error("merged bit count out of range");

endmodule
`default_nettype wire
